FILE: hdl/cubic_bezier_point_eval_assert.svh
// Assertion macros for the cubic Bezier point evaluator.
`ifndef CUBIC_BEZIER_POINT_EVAL_ASSERT_SVH
`define CUBIC_BEZIER_POINT_EVAL_ASSERT_SVH

`ifndef SYNTHESIS

`define CBPE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbpe: same-cycle check failed");

`define CBPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbpe: next-cycle check failed");

`else

`define CBPE_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define CBPE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/cbpe_pkg.sv
// Shared widths, types and arithmetic helpers for the cubic Bezier evaluator.
`default_nettype none

package cbpe_pkg;

   localparam int COORD_BITS   = 16;
   localparam int FRAC_BITS    = 16;
   localparam int PARAM_BITS   = FRAC_BITS + 1;
   localparam int WEIGHT_BITS  = FRAC_BITS + 1;
   localparam int SQ_BITS      = 2 * PARAM_BITS;
   localparam int TRIPLE_BITS  = SQ_BITS + 2;
   localparam int PROD_BITS    = COORD_BITS + WEIGHT_BITS + 1;
   localparam int SUM_BITS     = COORD_BITS + 2;
   localparam int SHIFTED_BITS = SUM_BITS + FRAC_BITS;
   localparam int ACC_BITS     = ((SHIFTED_BITS > PROD_BITS) ? SHIFTED_BITS : PROD_BITS) + 1;
   localparam int NUM_TERMS    = 4;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [PARAM_BITS-1:0] ONE_FX = PARAM_BITS'(64'd1 << FRAC_BITS);
   localparam logic [ACC_BITS-1:0]   TRUNC_BIAS = ACC_BITS'((64'd1 << FRAC_BITS) - 64'd1);

   typedef logic [PARAM_BITS-1:0]         param_type;
   typedef logic [WEIGHT_BITS-1:0]        weight_type;
   typedef logic [COORD_BITS-1:0]         coord_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;

   localparam sum_type SUM_HI = SUM_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam sum_type SUM_LO = SUM_BITS'(-(64'sd1 <<< (COORD_BITS - 1)));

   typedef struct packed {
      weight_type [NUM_TERMS-1:0] w;
   } weight_vec_type;

   typedef struct packed {
      coord_type [NUM_TERMS-1:0] xs;
      coord_type [NUM_TERMS-1:0] ys;
   } point_set_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_POINT0_X = 3'd0,
      REG_POINT0_Y = 3'd1,
      REG_POINT1_X = 3'd2,
      REG_POINT1_Y = 3'd3,
      REG_POINT2_X = 3'd4,
      REG_POINT2_Y = 3'd5,
      REG_POINT3_X = 3'd6,
      REG_POINT3_Y = 3'd7
   } csr_index_type;

   // One accumulation term: scale up the running sum, add, truncate toward zero.
   function automatic sum_type acc_term(input sum_type s, input prod_type p);
      acc_type t;
      acc_type tb;
      t  = (ACC_BITS'(s) <<< FRAC_BITS) + ACC_BITS'(p);
      tb = t + (t[ACC_BITS-1] ? TRUNC_BIAS : '0);
      return SUM_BITS'(tb >>> FRAC_BITS);
   endfunction

   function automatic coord_type sat_coord(input sum_type s);
      sum_type c;
      c = s;
      if (s > SUM_HI) c = SUM_HI;
      if (s < SUM_LO) c = SUM_LO;
      return c[COORD_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hdl/cbpe_req_if.sv
// Input channel: curve parameter words.
`default_nettype none

interface cbpe_req_if;
   import cbpe_pkg::*;

   logic      valid;
   logic      ready;
   param_type curve_param;

   modport source (output valid, output curve_param, input ready);
   modport sink   (input valid, input curve_param, output ready);
endinterface

`default_nettype wire

FILE: hdl/cbpe_rsp_if.sv
// Result channel: evaluated curve point words.
`default_nettype none

interface cbpe_rsp_if;
   import cbpe_pkg::*;

   logic      valid;
   logic      ready;
   coord_type curve_x;
   coord_type curve_y;

   modport source (output valid, output curve_x, output curve_y, input ready);
   modport sink   (input valid, input curve_x, input curve_y, output ready);
endinterface

`default_nettype wire

FILE: hdl/cbpe_csr.sv
// Control point register file.
`default_nettype none

module cbpe_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [cbpe_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [cbpe_pkg::COORD_BITS-1:0]    csr_wdata,
   output cbpe_pkg::point_set_type                 points
);
   import cbpe_pkg::*;

   point_set_type points_ff;
   point_set_type points_in;

   always_comb begin
      points_in = points_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            REG_POINT0_X: points_in.xs[0] = csr_wdata;
            REG_POINT0_Y: points_in.ys[0] = csr_wdata;
            REG_POINT1_X: points_in.xs[1] = csr_wdata;
            REG_POINT1_Y: points_in.ys[1] = csr_wdata;
            REG_POINT2_X: points_in.xs[2] = csr_wdata;
            REG_POINT2_Y: points_in.ys[2] = csr_wdata;
            REG_POINT3_X: points_in.xs[3] = csr_wdata;
            REG_POINT3_Y: points_in.ys[3] = csr_wdata;
            default:      points_in = points_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= '0;
      end else begin
         points_ff <= points_in;
      end
   end

   assign points = points_ff;

endmodule

`default_nettype wire

FILE: hdl/cbpe_weights.sv
// Bernstein weight pipeline: clamp, squares, cubic weights.
`default_nettype none

module cbpe_weights (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic [cbpe_pkg::PARAM_BITS-1:0] in_param,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output cbpe_pkg::weight_vec_type             out_weights
);
   import cbpe_pkg::*;

   logic [2:0] vld_ff;
   logic [2:0] vld_in;
   logic [2:0] en;

   param_type u1_ff, v1_ff, u1_in, v1_in;
   param_type u2_ff, v2_ff, uu_ff, vv_ff, uu_in, vv_in;
   weight_vec_type w_ff, w_in;

   logic [SQ_BITS-1:0]     uu_full, vv_full, w0_full, w3_full, m1_full, m2_full;
   logic [TRIPLE_BITS-1:0] t1_full, t2_full;

   assign en[2] = !vld_ff[2] || out_ready;
   assign en[1] = !vld_ff[1] || en[2];
   assign en[0] = !vld_ff[0] || en[1];

   assign vld_in[0] = en[0] ? in_valid  : vld_ff[0];
   assign vld_in[1] = en[1] ? vld_ff[0] : vld_ff[1];
   assign vld_in[2] = en[2] ? vld_ff[1] : vld_ff[2];

   // parameter above one saturates to one
   always_comb begin
      u1_in = (in_param > ONE_FX) ? ONE_FX : in_param;
      v1_in = ONE_FX - u1_in;
   end

   always_comb begin
      uu_full = SQ_BITS'(u1_ff) * SQ_BITS'(u1_ff);
      vv_full = SQ_BITS'(v1_ff) * SQ_BITS'(v1_ff);
      uu_in   = uu_full[FRAC_BITS +: PARAM_BITS];
      vv_in   = vv_full[FRAC_BITS +: PARAM_BITS];
   end

   always_comb begin
      w0_full = SQ_BITS'(vv_ff) * SQ_BITS'(v2_ff);
      w3_full = SQ_BITS'(uu_ff) * SQ_BITS'(u2_ff);
      m1_full = SQ_BITS'(u2_ff) * SQ_BITS'(vv_ff);
      m2_full = SQ_BITS'(uu_ff) * SQ_BITS'(v2_ff);
      t1_full = TRIPLE_BITS'(m1_full) + (TRIPLE_BITS'(m1_full) << 1);
      t2_full = TRIPLE_BITS'(m2_full) + (TRIPLE_BITS'(m2_full) << 1);
      w_in.w[0] = w0_full[FRAC_BITS +: WEIGHT_BITS];
      w_in.w[1] = t1_full[FRAC_BITS +: WEIGHT_BITS];
      w_in.w[2] = t2_full[FRAC_BITS +: WEIGHT_BITS];
      w_in.w[3] = w3_full[FRAC_BITS +: WEIGHT_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         u1_ff <= u1_in;
         v1_ff <= v1_in;
      end
      if (en[1]) begin
         u2_ff <= u1_ff;
         v2_ff <= v1_ff;
         uu_ff <= uu_in;
         vv_ff <= vv_in;
      end
      if (en[2]) begin
         w_ff <= w_in;
      end
   end

   assign in_ready    = en[0];
   assign out_valid   = vld_ff[2];
   assign out_weights = w_ff;

endmodule

`default_nettype wire

FILE: hdl/cbpe_accum.sv
// Weighted products and term-by-term truncating accumulation for both axes.
`default_nettype none

module cbpe_accum (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire cbpe_pkg::weight_vec_type            in_weights,
   input  wire cbpe_pkg::point_set_type             points,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic [cbpe_pkg::COORD_BITS-1:0]          out_x,
   output logic [cbpe_pkg::COORD_BITS-1:0]          out_y
);
   import cbpe_pkg::*;

   localparam int NUM_STAGES = NUM_TERMS + 1;

   logic [NUM_STAGES-1:0] vld_ff, vld_in, en;

   // stage 0 holds the products; stage k (1..NUM_TERMS-1) holds the sum after term k-1
   prod_type px_ff [NUM_TERMS][NUM_TERMS];
   prod_type py_ff [NUM_TERMS][NUM_TERMS];
   prod_type px_in [NUM_TERMS];
   prod_type py_in [NUM_TERMS];
   sum_type  sx_ff [NUM_TERMS];
   sum_type  sy_ff [NUM_TERMS];
   sum_type  sx_in [NUM_TERMS];
   sum_type  sy_in [NUM_TERMS];
   sum_type  fx_in, fy_in;
   coord_type x_ff, y_ff;

   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[0] = en[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_comb begin
      for (int j = 0; j < NUM_TERMS; j++) begin
         px_in[j] = $signed(points.xs[j]) * $signed({1'b0, in_weights.w[j]});
         py_in[j] = $signed(points.ys[j]) * $signed({1'b0, in_weights.w[j]});
      end
      sx_in[0] = '0;
      sy_in[0] = '0;
      for (int k = 1; k < NUM_TERMS; k++) begin
         sx_in[k] = acc_term(sx_ff[k-1], px_ff[k-1][k-1]);
         sy_in[k] = acc_term(sy_ff[k-1], py_ff[k-1][k-1]);
      end
      fx_in = acc_term(sx_ff[NUM_TERMS-1], px_ff[NUM_TERMS-1][NUM_TERMS-1]);
      fy_in = acc_term(sy_ff[NUM_TERMS-1], py_ff[NUM_TERMS-1][NUM_TERMS-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int j = 0; j < NUM_TERMS; j++) begin
            px_ff[0][j] <= px_in[j];
            py_ff[0][j] <= py_in[j];
         end
         sx_ff[0] <= sx_in[0];
         sy_ff[0] <= sy_in[0];
      end
      for (int k = 1; k < NUM_TERMS; k++) begin
         if (en[k]) begin
            px_ff[k] <= px_ff[k-1];
            py_ff[k] <= py_ff[k-1];
            sx_ff[k] <= sx_in[k];
            sy_ff[k] <= sy_in[k];
         end
      end
      if (en[NUM_STAGES-1]) begin
         x_ff <= sat_coord(fx_in);
         y_ff <= sat_coord(fy_in);
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NUM_STAGES-1];
   assign out_x     = x_ff;
   assign out_y     = y_ff;

endmodule

`default_nettype wire

FILE: hdl/cubic_bezier_point_eval.sv
// Cubic Bezier point evaluator: top level.
//
// req_chan carries one curve parameter u per word (unsigned, 1 << 16 is 1.0;
// larger values are treated as 1.0). rsp_chan returns the curve point (x, y)
// for each word, in order. The four control points are written through the
// csr_ port (index 0..7: p0.x, p0.y, p1.x, ... p3.y); the user must write them
// only while no word is in flight; the block itself does not enforce this.
// One word is accepted per cycle while rsp_chan is not stalled. There are eight
// register stages: three form the Bernstein weights (clamp, squares, cubes), one
// forms the eight coordinate products and four fold in the terms with
// truncation toward zero, the last one also saturating into the output
// register. Each stage has its own valid bit; a stage moves when it is empty or
// the one after it moves, so bubbles close up and req_chan.ready drops only when
// every stage is full and rsp_chan is stalled. Nothing is lost or repeated.
// Reset empties the pipeline and clears all control points to zero.
`default_nettype none

`include "cubic_bezier_point_eval_assert.svh"

module cubic_bezier_point_eval (
   input  wire logic                               clock,
   input  wire logic                               reset,
   cbpe_req_if.sink                                req_chan,
   cbpe_rsp_if.source                              rsp_chan,
   input  wire logic                               csr_wr_en,
   input  wire logic [cbpe_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [cbpe_pkg::COORD_BITS-1:0]    csr_wdata
);
   import cbpe_pkg::*;

   point_set_type  points;
   weight_vec_type wgt;
   logic           wgt_valid;
   logic           wgt_ready;

   cbpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .points    (points)
   );

   cbpe_weights u_weights (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_param    (req_chan.curve_param),
      .out_valid   (wgt_valid),
      .out_ready   (wgt_ready),
      .out_weights (wgt)
   );

   cbpe_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (wgt_valid),
      .in_ready   (wgt_ready),
      .in_weights (wgt),
      .points     (points),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_x      (rsp_chan.curve_x),
      .out_y      (rsp_chan.curve_y)
   );

   `CBPE_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_chan.valid)
   `CBPE_ASSERT_SAME(a_backpressure_source, clock, reset, !req_chan.ready, rsp_chan.valid && !rsp_chan.ready)
   `CBPE_ASSERT_SAME(a_weight_stall_full, clock, reset, wgt_valid && !wgt_ready, rsp_chan.valid && !rsp_chan.ready)

endmodule

`default_nettype wire
